// File: src/dqc_pkg.sv
`timescale 1ns / 1ps

package dqc_pkg;

   typedef enum logic [2:0] {
      PH_HEADER      = 3'd0,
      PH_LABEL_START = 3'd1,
      PH_AFTER_LEN   = 3'd2,
      PH_LABEL_BODY  = 3'd3,
      PH_QUERY       = 3'd4,
      PH_CLASS_OK    = 3'd5,
      PH_CLASS_BAD   = 3'd6
   } phase_type;

   typedef enum logic [3:0] {
      ST_OK        = 4'd0,
      ST_SHORT     = 4'd1,
      ST_LONG      = 4'd2,
      ST_QR        = 4'd3,
      ST_OPCODE    = 4'd4,
      ST_QDCOUNT   = 4'd5,
      ST_NOEND     = 4'd6,
      ST_NAMELONG  = 4'd7,
      ST_LABELLONG = 4'd8,
      ST_OVERRUN   = 4'd9,
      ST_NOQUERY   = 4'd10,
      ST_CLASS     = 4'd11
   } status_type;

   typedef enum logic {
      KIND_CHAR    = 1'b0,
      KIND_VERDICT = 1'b1
   } kind_type;

   localparam logic [1:0] CSR_MIN_LEN = 2'd0;
   localparam logic [1:0] CSR_MAX_LEN = 2'd1;

   localparam logic [15:0] MIN_LEN_RESET = 16'd17;
   localparam logic [15:0] MAX_LEN_RESET = 16'd1472;

   localparam logic [7:0]  CHAR_DOT     = 8'h2E;
   localparam logic [15:0] CLASS_IN     = 16'd1;
   localparam logic [15:0] QDCOUNT_ONE  = 16'd1;
   localparam int          HEADER_BYTES = 12;
   localparam logic [8:0]  ENC_MAX      = 9'd511;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] name_char;
      status_type status;
      logic [7:0] name_length;
      logic       last;
   } rsp_type;

   // up to two result words per input byte, first slot filled first
   typedef struct packed {
      logic    v0;
      logic    v1;
      rsp_type r0;
      rsp_type r1;
   } push_type;

endpackage

// File: src/dqc_parser.sv
`timescale 1ns / 1ps

module dqc_parser #(
   parameter int NAME_MAX_BYTES  = 255,
   parameter int LABEL_MAX_BYTES = 63,
   parameter int LENGTH_BITS     = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [7:0]        data_byte,
   input  logic              expect_query,
   input  logic              last_byte,
   input  logic [15:0]       min_len,
   input  logic [15:0]       max_len,
   output dqc_pkg::push_type push
);

   localparam logic [LENGTH_BITS-1:0] POS_MAX = '1;

   logic [LENGTH_BITS-1:0] pos_ff, pos_in, step_pos;
   logic                   want_query_ff, want_query_in, step_want;
   dqc_pkg::phase_type     phase_ff, phase_in, step_phase;
   dqc_pkg::status_type    hdr_err_ff, hdr_err_in, step_hdr_err;
   logic [7:0]             cnt_hi_ff, cnt_hi_in, step_cnt_hi;
   logic [7:0]             lab_rem_ff, lab_rem_in, step_lab_rem;
   logic [8:0]             enc_len_ff, enc_len_in, step_enc_len;
   logic                   first_ff, first_in, step_first;
   dqc_pkg::status_type    lab_err_ff, lab_err_in, step_lab_err;
   logic [2:0]             qseen_ff, qseen_in, step_qseen;
   logic [7:0]             class_hi_ff, class_hi_in, step_class_hi;

   logic                   in_name;
   logic                   label_long;
   logic                   char_valid;
   logic [7:0]             char_val;
   dqc_pkg::status_type    verdict;
   logic [15:0]            pkt_len;
   dqc_pkg::rsp_type       char_rsp, verdict_rsp;

   assign in_name = (phase_ff == dqc_pkg::PH_LABEL_START) ||
                    (phase_ff == dqc_pkg::PH_AFTER_LEN) ||
                    (phase_ff == dqc_pkg::PH_LABEL_BODY);

   assign label_long = (phase_ff == dqc_pkg::PH_AFTER_LEN) &&
                       (lab_rem_ff > 8'(LABEL_MAX_BYTES)) &&
                       (lab_err_ff == dqc_pkg::ST_OK);

   // next state: one byte's step, then the per-packet clear on the last byte
   always_comb begin
      step_pos      = pos_ff;
      step_want     = want_query_ff;
      step_phase    = phase_ff;
      step_hdr_err  = hdr_err_ff;
      step_cnt_hi   = cnt_hi_ff;
      step_lab_rem  = lab_rem_ff;
      step_enc_len  = enc_len_ff;
      step_first    = first_ff;
      step_lab_err  = lab_err_ff;
      step_qseen    = qseen_ff;
      step_class_hi = class_hi_ff;

      if (pos_ff == '0) step_want = expect_query;

      case (phase_ff)
         dqc_pkg::PH_HEADER: begin
            if (pos_ff == LENGTH_BITS'(2)) begin
               if (data_byte[7] != !step_want) begin
                  step_hdr_err = dqc_pkg::ST_QR;
               end else if (data_byte[6:3] != 4'd0) begin
                  step_hdr_err = dqc_pkg::ST_OPCODE;
               end
            end else if (pos_ff == LENGTH_BITS'(4)) begin
               step_cnt_hi = data_byte;
            end else if (pos_ff == LENGTH_BITS'(5)) begin
               if (hdr_err_ff == dqc_pkg::ST_OK &&
                   {cnt_hi_ff, data_byte} != dqc_pkg::QDCOUNT_ONE) begin
                  step_hdr_err = dqc_pkg::ST_QDCOUNT;
               end
            end
            if (pos_ff == LENGTH_BITS'(dqc_pkg::HEADER_BYTES - 1)) begin
               step_phase = dqc_pkg::PH_LABEL_START;
            end
         end
         dqc_pkg::PH_LABEL_START, dqc_pkg::PH_AFTER_LEN,
         dqc_pkg::PH_LABEL_BODY: begin
            if (enc_len_ff != dqc_pkg::ENC_MAX) step_enc_len = enc_len_ff + 9'd1;
            if (data_byte == 8'd0) begin
               if (phase_ff != dqc_pkg::PH_LABEL_START &&
                   lab_err_ff == dqc_pkg::ST_OK) begin
                  step_lab_err = dqc_pkg::ST_OVERRUN;
               end
               step_phase = dqc_pkg::PH_QUERY;
            end else if (phase_ff == dqc_pkg::PH_LABEL_START) begin
               step_first   = 1'b0;
               step_lab_rem = data_byte;
               step_phase   = dqc_pkg::PH_AFTER_LEN;
            end else begin
               if (label_long) step_lab_err = dqc_pkg::ST_LABELLONG;
               step_lab_rem = lab_rem_ff - 8'd1;
               step_phase   = (step_lab_rem != 8'd0) ? dqc_pkg::PH_LABEL_BODY
                                                     : dqc_pkg::PH_LABEL_START;
            end
         end
         dqc_pkg::PH_QUERY: begin
            if (qseen_ff == 3'd2) step_class_hi = data_byte;
            if (qseen_ff == 3'd3) begin
               step_phase = ({class_hi_ff, data_byte} == dqc_pkg::CLASS_IN)
                            ? dqc_pkg::PH_CLASS_OK : dqc_pkg::PH_CLASS_BAD;
            end
            if (qseen_ff < 3'd4) step_qseen = qseen_ff + 3'd1;
         end
         default: begin
         end
      endcase

      if (pos_ff != POS_MAX) step_pos = pos_ff + LENGTH_BITS'(1);

      if (last_byte) begin
         pos_in        = '0;
         want_query_in = 1'b0;
         phase_in      = dqc_pkg::PH_HEADER;
         hdr_err_in    = dqc_pkg::ST_OK;
         cnt_hi_in     = 8'd0;
         lab_rem_in    = 8'd0;
         enc_len_in    = 9'd0;
         first_in      = 1'b1;
         lab_err_in    = dqc_pkg::ST_OK;
         qseen_in      = 3'd0;
         class_hi_in   = 8'd0;
      end else begin
         pos_in        = step_pos;
         want_query_in = step_want;
         phase_in      = step_phase;
         hdr_err_in    = step_hdr_err;
         cnt_hi_in     = step_cnt_hi;
         lab_rem_in    = step_lab_rem;
         enc_len_in    = step_enc_len;
         first_in      = step_first;
         lab_err_in    = step_lab_err;
         qseen_in      = step_qseen;
         class_hi_in   = step_class_hi;
      end
   end

   // outputs: name character and verdict for this byte
   always_comb begin
      char_valid = 1'b0;
      char_val   = data_byte;
      if (in_name) begin
         if (data_byte == 8'd0) begin
            char_valid = first_ff && (hdr_err_ff == dqc_pkg::ST_OK);
            char_val   = dqc_pkg::CHAR_DOT;
         end else if (phase_ff == dqc_pkg::PH_LABEL_START) begin
            char_valid = !first_ff && (hdr_err_ff == dqc_pkg::ST_OK) &&
                         (lab_err_ff == dqc_pkg::ST_OK);
            char_val   = dqc_pkg::CHAR_DOT;
         end else begin
            char_valid = (hdr_err_ff == dqc_pkg::ST_OK) &&
                         (lab_err_ff == dqc_pkg::ST_OK) && !label_long;
         end
      end

      pkt_len = 16'(step_pos);
      if (pkt_len < min_len) begin
         verdict = dqc_pkg::ST_SHORT;
      end else if (pkt_len > max_len) begin
         verdict = dqc_pkg::ST_LONG;
      end else if (pkt_len < 16'(dqc_pkg::HEADER_BYTES)) begin
         verdict = dqc_pkg::ST_SHORT;
      end else if (step_hdr_err != dqc_pkg::ST_OK) begin
         verdict = step_hdr_err;
      end else if (step_phase < dqc_pkg::PH_QUERY) begin
         verdict = dqc_pkg::ST_NOEND;
      end else if (step_enc_len > 9'(NAME_MAX_BYTES)) begin
         verdict = dqc_pkg::ST_NAMELONG;
      end else if (step_lab_err != dqc_pkg::ST_OK) begin
         verdict = step_lab_err;
      end else if (step_phase == dqc_pkg::PH_QUERY) begin
         verdict = dqc_pkg::ST_NOQUERY;
      end else if (step_phase == dqc_pkg::PH_CLASS_BAD) begin
         verdict = dqc_pkg::ST_CLASS;
      end else begin
         verdict = dqc_pkg::ST_OK;
      end

      char_rsp.kind        = dqc_pkg::KIND_CHAR;
      char_rsp.name_char   = char_val;
      char_rsp.status      = dqc_pkg::ST_OK;
      char_rsp.name_length = 8'd0;
      char_rsp.last        = 1'b0;

      verdict_rsp.kind        = dqc_pkg::KIND_VERDICT;
      verdict_rsp.name_char   = 8'd0;
      verdict_rsp.status      = verdict;
      verdict_rsp.name_length = (verdict == dqc_pkg::ST_OK) ? step_enc_len[7:0] : 8'd0;
      verdict_rsp.last        = 1'b1;

      push.r1 = verdict_rsp;
      if (char_valid) begin
         push.v0 = accept;
         push.v1 = accept && last_byte;
         push.r0 = char_rsp;
      end else begin
         push.v0 = accept && last_byte;
         push.v1 = 1'b0;
         push.r0 = verdict_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         want_query_ff <= 1'b0;
         phase_ff      <= dqc_pkg::PH_HEADER;
         hdr_err_ff    <= dqc_pkg::ST_OK;
         cnt_hi_ff     <= 8'd0;
         lab_rem_ff    <= 8'd0;
         enc_len_ff    <= 9'd0;
         first_ff      <= 1'b1;
         lab_err_ff    <= dqc_pkg::ST_OK;
         qseen_ff      <= 3'd0;
         class_hi_ff   <= 8'd0;
      end else if (accept) begin
         pos_ff        <= pos_in;
         want_query_ff <= want_query_in;
         phase_ff      <= phase_in;
         hdr_err_ff    <= hdr_err_in;
         cnt_hi_ff     <= cnt_hi_in;
         lab_rem_ff    <= lab_rem_in;
         enc_len_ff    <= enc_len_in;
         first_ff      <= first_in;
         lab_err_ff    <= lab_err_in;
         qseen_ff      <= qseen_in;
         class_hi_ff   <= class_hi_in;
      end
   end

endmodule

// File: src/dqc_out_fifo.sv
`timescale 1ns / 1ps

module dqc_out_fifo (
   input  logic              clock,
   input  logic              reset,
   input  dqc_pkg::push_type push,
   input  logic              pop,
   output logic              room,
   output logic              not_empty,
   output dqc_pkg::rsp_type  head
);

   dqc_pkg::rsp_type mem [4];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;

   // keep space for the two words one byte may produce
   assign room      = (count_ff <= 3'd2);
   assign not_empty = (count_ff != 3'd0);
   assign head      = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff + 2'(push.v0) + 2'(push.v1);
      rd_ptr_in = rd_ptr_ff + 2'(pop);
      count_in  = count_ff + 3'(push.v0) + 3'(push.v1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.v0) mem[wr_ptr_ff] <= push.r0;
      if (push.v1) mem[wr_ptr_ff + 2'd1] <= push.r1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff  <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: src/dns_question_checker_core.sv
`timescale 1ns / 1ps
// Throughput: one message byte per cycle while req_tready is high; a byte closing a
//   packet whose name character is also emitted yields two words, drained one per
//   cycle while rsp_tready is high by the four-entry output queue, which holds
//   req_tready low while it has fewer than two free.
// Reset: synchronous, active high; clears packet state and the queue, and sets
//   min_packet_len to 17 and max_packet_len to 1472.
module dns_question_checker_core #(
   parameter int NAME_MAX_BYTES  = 255,
   parameter int LABEL_MAX_BYTES = 63,
   parameter int LENGTH_BITS     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] expect_query
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] name_char, [11:8] status, [19:12] name_length
   output logic        rsp_tuser,   // [0] kind
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic              [15:0] min_len_ff, min_len_in;
   logic              [15:0] max_len_ff, max_len_in;
   logic                     req_accept;
   logic                     rsp_pop;
   logic                     room;
   dqc_pkg::push_type        push;
   dqc_pkg::rsp_type         head;

   assign csr_ready  = 1'b1;
   assign req_tready = room;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_pop    = rsp_tvalid && rsp_tready;

   always_comb begin
      min_len_in = min_len_ff;
      max_len_in = max_len_ff;
      if (csr_valid) begin
         case (csr_index)
            dqc_pkg::CSR_MIN_LEN: min_len_in = csr_data;
            dqc_pkg::CSR_MAX_LEN: max_len_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= dqc_pkg::MIN_LEN_RESET;
         max_len_ff <= dqc_pkg::MAX_LEN_RESET;
      end else begin
         min_len_ff <= min_len_in;
         max_len_ff <= max_len_in;
      end
   end

   dqc_parser #(
      .NAME_MAX_BYTES  (NAME_MAX_BYTES),
      .LABEL_MAX_BYTES (LABEL_MAX_BYTES),
      .LENGTH_BITS     (LENGTH_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_tdata),
      .expect_query (req_tuser),
      .last_byte    (req_tlast),
      .min_len      (min_len_ff),
      .max_len      (max_len_ff),
      .push         (push)
   );

   dqc_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_pop),
      .room      (room),
      .not_empty (rsp_tvalid),
      .head      (head)
   );

   assign rsp_tdata = {4'd0, head.name_length, head.status, head.name_char};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

   a_reset_empty : assert property (@(posedge clock) (!reset && $past(reset)) |-> !rsp_tvalid)
      else $error("output queue not empty after reset");

   a_verdict_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (head.kind == dqc_pkg::KIND_VERDICT)))
      else $error("packet end mark does not match verdict word");

   a_len_only_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.status != dqc_pkg::ST_OK) |-> (head.name_length == 8'd0))
      else $error("name length reported with failing status");

   a_char_clean : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && head.kind == dqc_pkg::KIND_CHAR) |->
         (head.status == dqc_pkg::ST_OK && head.name_char != 8'd0))
      else $error("malformed name character word");

endmodule
